/* rtl/core/mvs_pkg.sv */
// Motion vector statistics: shared constants, command codes and control types.
`default_nettype none
package mvs_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int COMPONENT_BITS = 12;
  localparam int SUM_BITS       = COUNT_BITS + COMPONENT_BITS;
  localparam int ANSWER_BITS    = COMPONENT_BITS + 1;
  localparam int CHANNELS       = 4;
  localparam int CHAN_BITS      = 2;
  localparam int CMD_BITS       = 2;
  localparam int STEP_BITS      = $clog2(COMPONENT_BITS);

  localparam logic [CMD_BITS-1:0] CMD_RECORD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY_MAX = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY_AVG = 2'd2;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = '1;
  localparam logic [ANSWER_BITS-1:0] ANSWER_NONE = '1;
  localparam logic [ANSWER_BITS-1:0] MAG_LIMIT   = ANSWER_BITS'(1) << (COMPONENT_BITS - 1);

  typedef struct packed {
    logic take;
    logic exec;
    logic step;
    logic push;
  } ctrl_t;

  typedef struct packed {
    logic div_go;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/mvs_if.sv */
// Motion vector statistics: request and result channel interfaces.
`default_nettype none
interface mvs_req_if;
  logic                                       valid;
  logic                                       ready;
  logic [mvs_pkg::CMD_BITS-1:0]               command;
  logic [mvs_pkg::CHAN_BITS-1:0]              channel;
  logic signed [mvs_pkg::COMPONENT_BITS-1:0]  component;

  modport source (output valid, command, channel, component, input ready);
  modport sink   (input valid, command, channel, component, output ready);
endinterface

interface mvs_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mvs_pkg::ANSWER_BITS-1:0]  answer;

  modport source (output valid, answer, input ready);
  modport sink   (input valid, answer, output ready);
endinterface
`default_nettype wire

/* rtl/core/mvs_datapath.sv */
// Motion vector statistics: per-channel stores, record update and restoring divider.
`default_nettype none
module mvs_datapath (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire mvs_pkg::ctrl_t                        ctrl,
  output mvs_pkg::stat_t                             stat,
  input  wire [mvs_pkg::CMD_BITS-1:0]                command,
  input  wire [mvs_pkg::CHAN_BITS-1:0]               channel,
  input  wire signed [mvs_pkg::COMPONENT_BITS-1:0]   component,
  output logic signed [mvs_pkg::ANSWER_BITS-1:0]     answer
);

  logic [mvs_pkg::COMPONENT_BITS-1:0] peak [mvs_pkg::CHANNELS];
  logic [mvs_pkg::SUM_BITS-1:0]       sum  [mvs_pkg::CHANNELS];
  logic [mvs_pkg::COUNT_BITS-1:0]     count[mvs_pkg::CHANNELS];

  logic [mvs_pkg::CMD_BITS-1:0]        cmd_q;
  logic [mvs_pkg::CHAN_BITS-1:0]       ch_q;
  logic [mvs_pkg::COMPONENT_BITS-1:0]  comp_q;
  logic [mvs_pkg::ANSWER_BITS-1:0]     res;
  logic [mvs_pkg::SUM_BITS-1:0]        rem;
  logic [mvs_pkg::SUM_BITS-1:0]        dvs;
  logic [mvs_pkg::COMPONENT_BITS-1:0]  quo;
  logic [mvs_pkg::STEP_BITS-1:0]       step_cnt;

  logic [mvs_pkg::COMPONENT_BITS-1:0]  mag;
  logic                                ge;
  logic [mvs_pkg::COMPONENT_BITS-1:0]  quo_next;

  assign mag      = comp_q[mvs_pkg::COMPONENT_BITS-1] ? (~comp_q + 1'b1) : comp_q;
  assign ge       = rem >= dvs;
  assign quo_next = {quo[mvs_pkg::COMPONENT_BITS-2:0], ge};

  assign stat.div_go   = (cmd_q == mvs_pkg::CMD_QUERY_AVG) && (count[ch_q] != '0);
  assign stat.div_last = (step_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mvs_pkg::CHANNELS; i++) begin
        peak[i]  <= '0;
        sum[i]   <= '0;
        count[i] <= '0;
      end
    end else if (ctrl.exec && cmd_q == mvs_pkg::CMD_RECORD) begin
      if (count[ch_q] != mvs_pkg::COUNT_MAX) begin
        count[ch_q] <= count[ch_q] + 1'b1;
        sum[ch_q]   <= sum[ch_q] + mvs_pkg::SUM_BITS'(mag);
      end
      if (mag > peak[ch_q]) begin
        peak[ch_q] <= mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cmd_q  <= command;
      ch_q   <= channel;
      comp_q <= component;
    end
    if (ctrl.exec) begin
      case (cmd_q)
        mvs_pkg::CMD_RECORD:    res <= '0;
        mvs_pkg::CMD_QUERY_MAX: res <= mvs_pkg::ANSWER_BITS'(peak[ch_q]);
        mvs_pkg::CMD_QUERY_AVG: res <= mvs_pkg::ANSWER_NONE;
        default:                res <= '0;
      endcase
      rem      <= sum[ch_q];
      dvs      <= mvs_pkg::SUM_BITS'(count[ch_q]) << (mvs_pkg::COMPONENT_BITS - 1);
      quo      <= '0;
      step_cnt <= mvs_pkg::STEP_BITS'(mvs_pkg::COMPONENT_BITS - 1);
    end
    if (ctrl.step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs      <= dvs >> 1;
      quo      <= quo_next;
      step_cnt <= step_cnt - 1'b1;
      if (stat.div_last) begin
        res <= mvs_pkg::ANSWER_BITS'(quo_next);
      end
    end
    if (ctrl.push) begin
      answer <= res;
    end
  end

  a_quotient_bounded: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && stat.div_last |=> res <= mvs_pkg::MAG_LIMIT)
    else $error("average above largest magnitude");

  a_peak_bounded: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec |=> mvs_pkg::ANSWER_BITS'(peak[$past(ch_q)]) <= mvs_pkg::MAG_LIMIT)
    else $error("peak magnitude out of range");

  a_step_after_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec && stat.div_go |=> step_cnt == mvs_pkg::STEP_BITS'(mvs_pkg::COMPONENT_BITS - 1))
    else $error("divider not started");

endmodule
`default_nettype wire

/* rtl/core/mvs_ctrl.sv */
// Motion vector statistics: sequencing state machine and result-valid flag.
`default_nettype none
module mvs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output mvs_pkg::ctrl_t       ctrl,
  input  wire mvs_pkg::stat_t  stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.take  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.div_go ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        ctrl.step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          ctrl.push  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> out_valid && state == S_IDLE)
    else $error("pushed result not presented");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> $past(state) == S_EXEC || $past(state) == S_DIV)
    else $error("divider entered out of sequence");

  a_take_then_exec: assert property (@(posedge clk) disable iff (rst)
    ctrl.take |=> state == S_EXEC)
    else $error("accepted beat not executed");

endmodule
`default_nettype wire

/* rtl/core/motion_vector_stats_unit.sv */
// Motion vector statistics unit: top level joining controller and datapath.
//
// Keeps peak magnitude, magnitude sum and sample count for four channels
// (horizontal/vertical, forward/backward). The request channel carries a
// command, a channel and a signed component; every request beat yields
// exactly one result beat on the result channel.
//   record    : magnitude added to sum and count (frozen once the count is
//               saturated), peak raised; answer 0.
//   query max : answer is the peak magnitude.
//   query avg : answer is sum / count, or -1 for an empty channel.
// Sequence: a request is accepted in the idle state, then passes through the
// execute and push states before the next one is accepted; an average of a
// non-empty channel also passes through the divide state, where the restoring
// divider retires one quotient bit per cycle over 12 bits.
// The result sits in an output register; a request is accepted while an
// earlier result still waits. If the receiver stalls, the finished result
// of the next request is held in the datapath until the output register
// frees, and no further request is taken meanwhile.
// Synchronous reset clears all statistics and empties the output register.
`default_nettype none
module motion_vector_stats_unit (
  input  wire        clk,
  input  wire        rst,
  mvs_req_if.sink    request,
  mvs_rsp_if.source  result
);

  mvs_pkg::ctrl_t ctrl;
  mvs_pkg::stat_t stat;

  mvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  mvs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .command   (request.command),
    .channel   (request.channel),
    .component (request.component),
    .answer    (result.answer)
  );

endmodule
`default_nettype wire
